@@ rtl/core/pwlm_pkg.sv @@
// ----------------------------------------------------------------------------
// pwlm_pkg
// Shared types and constants for the piecewise linear membership block:
// register map, sequencer states, level format and the unity cap.
// ----------------------------------------------------------------------------
package pwlm_pkg;

	// configuration port shape
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X0     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X1     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X2     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X3     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd5;

	// breakpoint storage
	localparam int NUM_XREG = 4;
	localparam int PIDX_W   = 2;
	localparam int COUNT_W  = 3;
	localparam logic [COUNT_W-1:0] MIN_POINTS = 3'd2;

	// Q1.15 levels and quotient
	localparam int LEVEL_W = 16;
	localparam int QUOT_W  = 16;
	localparam logic [LEVEL_W-1:0] ONE_Q15 = 16'h8000;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SETUP,
		ST_DIV,
		ST_FIN
	} pwlm_state_t;

	// clamp a level or quotient to 1.0
	function automatic logic [LEVEL_W-1:0] cap_one(input logic [LEVEL_W-1:0] v);
		return (v > ONE_Q15) ? ONE_Q15 : v;
	endfunction

endpackage

@@ rtl/core/piecewise_linear_membership.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_membership
// Fuzzy membership over up to four breakpoints: segment search, then a
// bit-serial division for sloped segments, result held in an output register.
// ----------------------------------------------------------------------------
// One request is worked on at a time. After it is taken the sequencer scans
// the breakpoints one per cycle, picks the segment in ST_SETUP, and for a
// sloped segment runs the restoring divider, one quotient bit per cycle,
// then hands the quotient over; flat or out-of-span samples skip the divider.
// The result waits in ST_FIN until the output register can take it, and the
// next request is taken once the sequencer is back in ST_IDLE. A new request
// is taken while a finished result still waits in the output register; a
// second finished result waits, with the input stalled, until that one is
// taken. Configuration must be written only while the block is idle; the
// block itself does not enforce this, and cfg_ready is always high.
module piecewise_linear_membership #(
	parameter int MAX_POINTS = 4,
	parameter int X_WIDTH    = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pwlm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pwlm_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input request
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [X_WIDTH-1:0]           sample_x,
	// result request
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pwlm_pkg::LEVEL_W-1:0]        degree,
	output logic                                in_range
);
	import pwlm_pkg::*;

	localparam logic [PIDX_W-1:0]  LAST_IDX  = PIDX_W'(MAX_POINTS - 1);
	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_POINTS);

	// configuration registers
	logic [COUNT_W-1:0]        count_q;
	logic signed [X_WIDTH-1:0] point_x_q [NUM_XREG];
	logic [CFG_DATA_W-1:0]     level_q;

	// sequencer
	pwlm_state_t               state_q, state_d;
	logic [PIDX_W-1:0]         idx_q;
	logic signed [X_WIDTH-1:0] x_q;
	logic                      any_le_q, any_ge_q;
	logic                      up_run_q, s_valid_q, e_valid_q;
	logic [PIDX_W-1:0]         s_idx_q, e_idx_q;
	logic [LEVEL_W-1:0]        res_deg_q;
	logic                      res_rng_q;

	// output register
	logic                      out_valid_q;
	logic [LEVEL_W-1:0]        degree_q;
	logic                      in_range_q;

	// combinational
	logic                      in_take;
	logic                      out_take;
	logic                      out_load;
	logic [COUNT_W-1:0]        cnt_eff;
	logic                      in_use;
	logic signed [X_WIDTH-1:0] xi;
	logic signed [X_WIDTH-1:0] xs, xe;
	logic [LEVEL_W-1:0]        ys, ye;
	logic [X_WIDTH:0]          denom_w, num_up_w, num_dn_w;
	logic                      span_ok;
	logic                      flat_w;
	logic                      div_start;
	logic [X_WIDTH-1:0]        div_num;
	logic                      div_done;
	logic [QUOT_W-1:0]         div_quot;
	logic                      res_load;
	logic [LEVEL_W-1:0]        res_deg_d;
	logic                      res_rng_d;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < NUM_XREG; i++) begin
				point_x_q[i] <= '0;
			end
			level_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COUNT:  count_q      <= cfg_data[COUNT_W-1:0];
				REG_X0:     point_x_q[0] <= cfg_data[X_WIDTH-1:0];
				REG_X1:     point_x_q[1] <= cfg_data[X_WIDTH-1:0];
				REG_X2:     point_x_q[2] <= cfg_data[X_WIDTH-1:0];
				REG_X3:     point_x_q[3] <= cfg_data[X_WIDTH-1:0];
				REG_LEVELS: level_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// breakpoints in use, count saturated
	assign cnt_eff = (count_q > MAX_COUNT) ? MAX_COUNT : count_q;
	assign in_use  = ({1'b0, idx_q} < cnt_eff);
	assign xi      = point_x_q[idx_q];

	// segment endpoints and differences
	assign xs       = point_x_q[s_idx_q];
	assign xe       = point_x_q[e_idx_q];
	assign ys       = level_q[LEVEL_W*s_idx_q +: LEVEL_W];
	assign ye       = level_q[LEVEL_W*e_idx_q +: LEVEL_W];
	assign denom_w  = {xe[X_WIDTH-1], xe} - {xs[X_WIDTH-1], xs};
	assign num_up_w = {x_q[X_WIDTH-1], x_q} - {xs[X_WIDTH-1], xs};
	assign num_dn_w = {xe[X_WIDTH-1], xe} - {x_q[X_WIDTH-1], x_q};
	assign span_ok  = (cnt_eff >= MIN_POINTS) && any_le_q && any_ge_q;
	assign flat_w   = (ye == ys) || denom_w[X_WIDTH] || (denom_w == '0);
	assign div_num  = (ye > ys) ? num_up_w[X_WIDTH-1:0] : num_dn_w[X_WIDTH-1:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and result selection
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		res_load  = 1'b0;
		res_deg_d = '0;
		res_rng_d = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (idx_q == LAST_IDX) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				res_rng_d = span_ok;
				if (!span_ok || !s_valid_q || !e_valid_q) begin
					res_load = 1'b1;
					state_d  = ST_FIN;
				end else if (flat_w) begin
					res_load  = 1'b1;
					res_deg_d = cap_one(ys);
					state_d   = ST_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				res_rng_d = 1'b1;
				res_deg_d = cap_one(div_quot);
				if (div_done) begin
					res_load = 1'b1;
					state_d  = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// scan bookkeeping: span flags and segment start and end search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			any_le_q  <= 1'b0;
			any_ge_q  <= 1'b0;
			up_run_q  <= 1'b0;
			s_valid_q <= 1'b0;
			e_valid_q <= 1'b0;
		end else if (in_take) begin
			idx_q     <= '0;
			any_le_q  <= 1'b0;
			any_ge_q  <= 1'b0;
			up_run_q  <= 1'b1;
			s_valid_q <= 1'b0;
			e_valid_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			idx_q <= idx_q + 1'b1;
			if (in_use) begin
				if (xi <= x_q) any_le_q <= 1'b1;
				if (xi >= x_q) any_ge_q <= 1'b1;
				// start: last point of the upward run with x at or above it
				if (up_run_q && (x_q >= xi)) begin
					s_valid_q <= 1'b1;
				end else begin
					up_run_q <= 1'b0;
				end
				// end: first point of the closing run with x at or below it
				if (x_q <= xi) begin
					if (!e_valid_q) e_valid_q <= 1'b1;
				end else begin
					e_valid_q <= 1'b0;
				end
			end
		end
	end

	// scan payload: sample and endpoint indexes
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q <= sample_x;
		end else if ((state_q == ST_SCAN) && in_use) begin
			if (up_run_q && (x_q >= xi)) s_idx_q <= idx_q;
			if ((x_q <= xi) && !e_valid_q) e_idx_q <= idx_q;
		end
	end

	// finished result awaiting the output register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_deg_q <= res_deg_d;
			res_rng_q <= res_rng_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			degree_q   <= res_deg_q;
			in_range_q <= res_rng_q;
		end
	end

	assign out_valid = out_valid_q;
	assign degree    = degree_q;
	assign in_range  = in_range_q;

	// bit-serial divider for sloped segments
	pwlm_div #(
		.X_WIDTH (X_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (denom_w[X_WIDTH-1:0]),
		.done   (div_done),
		.quot   (div_quot)
	);

	// checks
	a_deg_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (degree <= ONE_Q15))
		else $error("degree above unity");

	a_out_of_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_range) |-> (degree == '0))
		else $error("non-zero degree outside span");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid) && $past(arst_n)) |-> ($past(state_q) == ST_FIN))
		else $error("result presented without finishing");

endmodule

@@ rtl/core/pwlm_div.sv @@
// ----------------------------------------------------------------------------
// pwlm_div
// Restoring divider, one quotient bit per cycle, for num * 2^15 / den with
// num <= den; the quotient shifts in msb first.
// ----------------------------------------------------------------------------
module pwlm_div #(
	parameter int X_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [X_WIDTH-1:0]         num,
	input  logic [X_WIDTH-1:0]         den,
	output logic                       done,
	output logic [pwlm_pkg::QUOT_W-1:0] quot
);
	import pwlm_pkg::*;

	localparam int ITER_W = $clog2(QUOT_W);
	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(QUOT_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [ITER_W-1:0]   iter_q;
	logic [X_WIDTH:0]    rem_q;
	logic [X_WIDTH:0]    den_q;
	logic [QUOT_W-1:0]   quot_q;
	logic                bit_w;
	logic [X_WIDTH:0]    diff_w;
	logic [X_WIDTH:0]    next_rem_w;

	// trial subtract
	assign bit_w      = (rem_q >= den_q);
	assign diff_w     = bit_w ? (rem_q - den_q) : rem_q;
	assign next_rem_w = {diff_w[X_WIDTH-1:0], 1'b0};

	// control: iteration count and finish pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == LAST_ITER) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= {1'b0, den};
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= next_rem_w;
			quot_q <= {quot_q[QUOT_W-2:0], bit_w};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
